// File: hdl/gkem_pkg.sv
// Shared types, constants and lookup tables for the gamepad key event mapper.
package gkem_pkg;

    // Sizes of the binding store and capture timing.
    localparam int Actions        = 32;
    localparam int ActW           = $clog2(Actions);
    localparam int CaptureTimeout = 1800;
    localparam int TicksW         = 11;
    localparam int StepW          = 6;
    localparam int WordW          = 30;
    localparam int KeyW           = 9;
    localparam int BtnW           = 4;
    localparam int OutW           = 48;
    localparam int InW            = 72;

    // Configuration register indexes.
    localparam logic RegBindCount = 1'b0;
    localparam logic RegStickMove = 1'b1;

    // Analog thresholds.
    localparam logic signed [7:0] DeadPos = 8'sd20;
    localparam logic signed [7:0] DeadNeg = -8'sd20;
    localparam logic [7:0]        TrigOn  = 8'd64;

    // Button word bit positions.
    localparam int PbB     = 1;
    localparam int PbA     = 2;
    localparam int PbStart = 3;
    localparam int PbUp    = 4;
    localparam int PbDown  = 5;
    localparam int PbLeft  = 6;
    localparam int PbRight = 7;
    localparam int PbY     = 9;
    localparam int PbX     = 10;
    localparam int SbLeft  = 24;
    localparam int SbRight = 25;
    localparam int SbUp    = 26;
    localparam int SbDown  = 27;
    localparam int SbLt    = 28;
    localparam int SbRt    = 29;

    // Key codes.
    localparam logic [KeyW-1:0] KTab    = 9'd9;
    localparam logic [KeyW-1:0] KReturn = 9'd13;
    localparam logic [KeyW-1:0] KEsc    = 9'd27;
    localparam logic [KeyW-1:0] KQuote  = 9'd39;
    localparam logic [KeyW-1:0] KM      = 9'd109;
    localparam logic [KeyW-1:0] KX      = 9'd120;
    localparam logic [KeyW-1:0] KZ      = 9'd122;
    localparam logic [KeyW-1:0] KDel    = 9'd127;
    localparam logic [KeyW-1:0] KUp     = 9'd273;
    localparam logic [KeyW-1:0] KDown   = 9'd274;
    localparam logic [KeyW-1:0] KRight  = 9'd275;
    localparam logic [KeyW-1:0] KLeft   = 9'd276;
    localparam logic [KeyW-1:0] KLctrl  = 9'd306;

    localparam int NavRows  = 13;
    localparam int PlayRows = 9;

    typedef enum logic [2:0] {
        OP_POLL      = 3'd0,
        OP_SET_CTX   = 3'd1,
        OP_CAP_BEGIN = 3'd2,
        OP_CAP_END   = 3'd3,
        OP_CAP_TAKE  = 3'd4,
        OP_LOAD      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        SRC_NAV,
        SRC_PLAY,
        SRC_BIND
    } t_src;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST
    } t_state;

    // Controller to datapath commands.
    typedef struct packed {
        logic exec;
        logic step;
        logic flush;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic scan_done;
        logic can_step;
        logic out_free;
    } t_stat;

    // One input item, unpacked from the stream.
    typedef struct packed {
        logic [2:0]        operation;
        logic              pad_present;
        logic [15:0]       pad_buttons;
        logic signed [7:0] stick_x;
        logic signed [7:0] stick_y;
        logic [7:0]        trig_left;
        logic [7:0]        trig_right;
        logic              context_game;
        logic [4:0]        action_index;
        logic [3:0]        button_id;
        logic [KeyW-1:0]   key_code;
    } t_item;

    function automatic logic [WordW-1:0] bit_of(input int pos);
        logic [WordW-1:0] m;
        m = '0;
        m[pos] = 1'b1;
        return m;
    endfunction

    // Button id to button word mask; ids without a button give zero.
    function automatic logic [WordW-1:0] id_mask(input logic [BtnW-1:0] id);
        logic [WordW-1:0] m;
        m = '0;
        unique case (id)
            4'd1:    m = bit_of(PbA);
            4'd2:    m = bit_of(PbB);
            4'd3:    m = bit_of(PbX);
            4'd4:    m = bit_of(PbY);
            4'd5:    m = bit_of(PbUp);
            4'd6:    m = bit_of(PbDown);
            4'd7:    m = bit_of(PbLeft);
            4'd8:    m = bit_of(PbRight);
            4'd9:    m = bit_of(SbLt);
            4'd10:   m = bit_of(SbRt);
            4'd11:   m = bit_of(PbStart);
            default: m = '0;
        endcase
        return m;
    endfunction

    // Menu table rows.
    function automatic logic [WordW-1:0] nav_mask(input logic [3:0] r);
        logic [WordW-1:0] m;
        m = '0;
        unique case (r)
            4'd0:    m = bit_of(PbUp);
            4'd1:    m = bit_of(PbDown);
            4'd2:    m = bit_of(PbLeft);
            4'd3:    m = bit_of(PbRight);
            4'd4:    m = bit_of(SbUp);
            4'd5:    m = bit_of(SbDown);
            4'd6:    m = bit_of(SbLeft);
            4'd7:    m = bit_of(SbRight);
            4'd8:    m = bit_of(PbA);
            4'd9:    m = bit_of(PbStart);
            4'd10:   m = bit_of(PbX);
            4'd11:   m = bit_of(SbLt);
            4'd12:   m = bit_of(SbRt);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [KeyW-1:0] nav_key(input logic [3:0] r);
        logic [KeyW-1:0] k;
        k = '0;
        unique case (r)
            4'd0, 4'd4:   k = KUp;
            4'd1, 4'd5:   k = KDown;
            4'd2, 4'd6:   k = KLeft;
            4'd3, 4'd7:   k = KRight;
            4'd8:         k = KReturn;
            4'd9:         k = KEsc;
            4'd10:        k = KDel;
            4'd11, 4'd12: k = KTab;
            default:      k = '0;
        endcase
        return k;
    endfunction

    // Game table rows.
    function automatic logic [WordW-1:0] play_mask(input logic [3:0] r);
        logic [WordW-1:0] m;
        m = '0;
        unique case (r)
            4'd0:    m = bit_of(PbY);
            4'd1:    m = bit_of(PbA);
            4'd2:    m = bit_of(PbX);
            4'd3:    m = bit_of(PbB);
            4'd4:    m = bit_of(PbUp);
            4'd5:    m = bit_of(PbDown);
            4'd6:    m = bit_of(PbRight);
            4'd7:    m = bit_of(PbLeft);
            4'd8:    m = bit_of(PbStart);
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [KeyW-1:0] play_key(input logic [3:0] r);
        logic [KeyW-1:0] k;
        k = '0;
        unique case (r)
            4'd0:    k = KUp;
            4'd1:    k = KDown;
            4'd2:    k = KZ;
            4'd3:    k = KX;
            4'd4:    k = KTab;
            4'd5:    k = KM;
            4'd6:    k = KQuote;
            4'd7:    k = KLctrl;
            4'd8:    k = KEsc;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: hdl/gkem_ram.sv
// Generic single write port, single read port RAM with registered read data.
module gkem_ram #(
    parameter int Width = 8,
    parameter int Depth = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/gkem_ctrl.sv
// Controller state machine: accepts an item, walks the event scan, closes the result run.
module gkem_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  gkem_pkg::t_stat i_stat,
    output gkem_pkg::t_cmd  o_cmd
);
    import gkem_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = ST_LAST;
                end else begin
                    o_cmd.step = i_stat.can_step;
                end
            end
            ST_LAST: begin
                if (i_stat.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// File: hdl/gkem_dp.sv
// Datapath: poll processing, mode state, binding store, event scan and output register.
module gkem_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gkem_pkg::t_cmd               i_cmd,
    output gkem_pkg::t_stat              o_stat,
    input  gkem_pkg::t_item              i_item,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [5:0]                   i_cfg_data,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [gkem_pkg::OutW-1:0]    o_out_data,
    output logic                         o_out_last
);
    import gkem_pkg::*;

    // Configuration and persistent state.
    logic [5:0]             r_bind_count;
    logic                   r_stick_mode;
    logic [WordW-1:0]       r_prior;
    logic                   r_baseline;
    logic                   r_game;
    logic                   r_cap_active;
    logic signed [4:0]      r_cap_value;
    logic [TicksW-1:0]      r_cap_ticks;
    logic signed [7:0]      r_lat_x, r_lat_y;
    logic [7:0]             r_lat_l, r_lat_r;
    logic signed [4:0]      r_report;

    // Scan state.
    t_src                   r_src;
    logic [WordW-1:0]       r_cur, r_chg;
    logic [StepW-1:0]       r_idx, r_lim;
    logic                   r_pend_v;
    logic [KeyW-1:0]        r_pend_key;
    logic                   r_pend_pr;

    // Output register.
    logic                   r_out_v;
    logic [OutW-1:0]        r_out_data;
    logic                   r_out_last;

    // Next values from the item execution.
    logic [WordW-1:0]       n_prior;
    logic                   n_baseline, n_game, n_cap_active;
    logic signed [4:0]      n_cap_value, n_report;
    logic [TicksW-1:0]      n_cap_ticks;
    logic signed [7:0]      n_lat_x, n_lat_y;
    logic [7:0]             n_lat_l, n_lat_r;
    t_src                   n_src;
    logic [WordW-1:0]       n_cur, n_chg;
    logic [StepW-1:0]       n_lim;
    logic                   n_pend_v;

    // Poll helpers.
    logic signed [7:0]      dz_x, dz_y;
    logic [WordW-1:0]       poll_word, poll_chg, poll_press;
    logic [StepW-1:0]       bind_n;
    logic                   load_we;

    // Binding store.
    logic [BtnW+KeyW-1:0]   ram_rdata;
    logic [StepW-1:0]       n_idx;
    logic [StepW-1:0]       ram_step;

    // Step evaluation.
    logic [WordW-1:0]       s_mask;
    logic [KeyW-1:0]        s_key;
    logic [StepW-1:0]       bidx;
    logic                   s_hit, s_pr;
    logic                   out_free, push;
    logic                   p_kv, p_pr;
    logic [KeyW-1:0]        p_key;

    // Deadzone and button word for a poll.
    always_comb begin
        dz_x = (i_item.stick_x > DeadNeg && i_item.stick_x < DeadPos) ? 8'sd0 : i_item.stick_x;
        dz_y = (i_item.stick_y > DeadNeg && i_item.stick_y < DeadPos) ? 8'sd0 : i_item.stick_y;
        poll_word = {14'd0, i_item.pad_buttons};
        if (i_item.trig_left > TrigOn) begin
            poll_word[SbLt] = 1'b1;
        end
        if (i_item.trig_right > TrigOn) begin
            poll_word[SbRt] = 1'b1;
        end
        if (!r_game || r_stick_mode) begin
            poll_word[SbLeft]  = dz_x < 0;
            poll_word[SbRight] = dz_x > 0;
            poll_word[SbUp]    = dz_y < 0;
            poll_word[SbDown]  = dz_y > 0;
        end
        poll_chg   = poll_word ^ r_prior;
        poll_press = poll_chg & poll_word;
        bind_n     = (r_bind_count > StepW'(Actions)) ? StepW'(Actions) : r_bind_count;
    end

    // Execution of an accepted item.
    always_comb begin
        n_prior      = r_prior;
        n_baseline   = r_baseline;
        n_game       = r_game;
        n_cap_active = r_cap_active;
        n_cap_value  = r_cap_value;
        n_cap_ticks  = r_cap_ticks;
        n_lat_x      = r_lat_x;
        n_lat_y      = r_lat_y;
        n_lat_l      = r_lat_l;
        n_lat_r      = r_lat_r;
        n_report     = -5'sd1;
        n_src        = SRC_NAV;
        n_cur        = poll_word;
        n_chg        = poll_chg;
        n_lim        = '0;
        n_pend_v     = 1'b0;
        load_we      = 1'b0;
        unique case (i_item.operation)
            OP_POLL: begin
                if (!i_item.pad_present) begin
                    n_lat_x = '0;
                    n_lat_y = '0;
                    n_lat_l = '0;
                    n_lat_r = '0;
                end else begin
                    n_lat_x = dz_x;
                    n_lat_y = dz_y;
                    n_lat_l = i_item.trig_left;
                    n_lat_r = i_item.trig_right;
                    n_prior = poll_word;
                    if (!r_baseline) begin
                        n_baseline = 1'b1;
                    end else if (r_cap_active) begin
                        // Capture: the lowest id among new presses wins, Start reads as cancel.
                        if (poll_press != '0) begin
                            for (int b = 11; b >= 1; b--) begin
                                if ((poll_press & id_mask(BtnW'(b))) != '0) begin
                                    n_cap_value = (b == 11) ? 5'sd0 : 5'(b);
                                end
                            end
                        end else begin
                            if (r_cap_ticks >= TicksW'(CaptureTimeout)) begin
                                n_cap_value = 5'sd0;
                            end
                            if (r_cap_ticks != '1) begin
                                n_cap_ticks = r_cap_ticks + 1'b1;
                            end
                        end
                        n_pend_v = !n_cap_value[4];
                    end else if (poll_chg != '0) begin
                        if (r_game && r_bind_count != '0) begin
                            n_src = SRC_BIND;
                            n_lim = bind_n + 1'b1;
                        end else if (r_game) begin
                            n_src = SRC_PLAY;
                            n_lim = StepW'(PlayRows);
                        end else begin
                            n_src = SRC_NAV;
                            n_lim = StepW'(NavRows);
                        end
                    end
                end
            end
            OP_SET_CTX: begin
                // A context switch releases every key of the table being left.
                n_cur = '0;
                n_chg = '1;
                if (i_item.context_game != r_game) begin
                    n_game = i_item.context_game;
                    n_src  = i_item.context_game ? SRC_NAV : SRC_PLAY;
                    n_lim  = i_item.context_game ? StepW'(NavRows) : StepW'(PlayRows);
                end
            end
            OP_CAP_BEGIN: begin
                n_cap_active = 1'b1;
                n_cap_value  = -5'sd1;
                n_cap_ticks  = '0;
            end
            OP_CAP_END: begin
                n_cap_active = 1'b0;
                n_cap_value  = -5'sd1;
            end
            OP_CAP_TAKE: begin
                n_report = r_cap_value;
                if (!r_cap_value[4]) begin
                    n_cap_active = 1'b0;
                    n_cap_value  = -5'sd1;
                end
            end
            OP_LOAD: begin
                load_we = 32'(i_item.action_index) < Actions;
            end
            default: n_lim = '0;
        endcase
    end

    // Step index and binding read address; data for step k arrives in the cycle it is evaluated.
    assign n_idx    = i_cmd.exec ? '0 : (i_cmd.step ? r_idx + 1'b1 : r_idx);
    assign ram_step = n_idx - 1'b1;

    gkem_ram #(
        .Width (BtnW + KeyW),
        .Depth (Actions)
    ) u_bind_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && load_we),
        .i_waddr (i_item.action_index[ActW-1:0]),
        .i_wdata ({i_item.button_id, i_item.key_code}),
        .i_raddr (ram_step[ActW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Mask and key of the current scan step.
    always_comb begin
        s_mask = '0;
        s_key  = '0;
        bidx   = r_idx - 1'b1;
        unique case (r_src)
            SRC_NAV: begin
                s_mask = nav_mask(r_idx[3:0]);
                s_key  = nav_key(r_idx[3:0]);
            end
            SRC_PLAY: begin
                s_mask = play_mask(r_idx[3:0]);
                s_key  = play_key(r_idx[3:0]);
            end
            SRC_BIND: begin
                if (r_idx == '0) begin
                    s_mask = bit_of(PbStart);
                    s_key  = KEsc;
                end else begin
                    s_mask = id_mask(ram_rdata[BtnW+KeyW-1:KeyW]);
                    s_key  = ram_rdata[KeyW-1:0];
                    if (r_stick_mode) begin
                        s_mask[SbUp]    = s_mask[SbUp]    | (bidx == 6'd0);
                        s_mask[SbDown]  = s_mask[SbDown]  | (bidx == 6'd1);
                        s_mask[SbLeft]  = s_mask[SbLeft]  | (bidx == 6'd2);
                        s_mask[SbRight] = s_mask[SbRight] | (bidx == 6'd3);
                    end
                end
            end
            default: s_mask = '0;
        endcase
        s_hit = (s_mask & r_chg) != '0;
        s_pr  = (s_mask & r_cur) != '0;
    end

    // A found event waits for the next one, so the final one can carry the last mark.
    assign out_free = !r_out_v || i_out_ready;
    assign push     = (i_cmd.step && s_hit && r_pend_v) || i_cmd.flush;
    assign p_kv     = r_pend_v;
    assign p_key    = r_pend_v ? r_pend_key : '0;
    assign p_pr     = r_pend_v && r_pend_pr;

    assign o_stat.scan_done = r_idx == r_lim;
    assign o_stat.can_step  = !(s_hit && r_pend_v && !out_free);
    assign o_stat.out_free  = out_free;

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_count <= '0;
            r_stick_mode <= 1'b0;
            r_prior      <= '0;
            r_baseline   <= 1'b0;
            r_game       <= 1'b0;
            r_cap_active <= 1'b0;
            r_cap_value  <= -5'sd1;
            r_cap_ticks  <= '0;
            r_lat_x      <= '0;
            r_lat_y      <= '0;
            r_lat_l      <= '0;
            r_lat_r      <= '0;
            r_report     <= -5'sd1;
            r_src        <= SRC_NAV;
            r_idx        <= '0;
            r_lim        <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == RegBindCount) begin
                    r_bind_count <= i_cfg_data;
                end else begin
                    r_stick_mode <= i_cfg_data[0];
                end
            end
            r_idx <= n_idx;
            if (i_cmd.exec) begin
                r_prior      <= n_prior;
                r_baseline   <= n_baseline;
                r_game       <= n_game;
                r_cap_active <= n_cap_active;
                r_cap_value  <= n_cap_value;
                r_cap_ticks  <= n_cap_ticks;
                r_lat_x      <= n_lat_x;
                r_lat_y      <= n_lat_y;
                r_lat_l      <= n_lat_l;
                r_lat_r      <= n_lat_r;
                r_report     <= n_report;
                r_src        <= n_src;
                r_lim        <= n_lim;
                r_pend_v     <= n_pend_v;
            end else if (i_cmd.step && s_hit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Scan and output payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_cur      <= n_cur;
            r_chg      <= n_chg;
            r_pend_key <= '0;
            r_pend_pr  <= 1'b1;
        end else if (i_cmd.step && s_hit) begin
            r_pend_key <= s_key;
            r_pend_pr  <= s_pr;
        end
        if (push) begin
            r_out_data <= {r_lat_r, r_lat_l, r_lat_y, r_lat_x, r_report, p_pr, p_key, p_kv};
            r_out_last <= i_cmd.flush;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

// File: hdl/gamepad_to_key_event_mapper.sv
// Top level of the gamepad to key event mapper: stream ports, controller and datapath.
// Sequence: an item is taken while idle, then the scan takes one step per table row or binding
// (13 menu rows, 9 game rows, or the binding count, capped at 32, plus one), then the controller
// sees the scan end and closes the run; a new item is taken only after the run is closed.
// A binding poll walks the store through one RAM read port, one entry per cycle while the output
// does not stall.
// Reset: synchronous, active low; clears configuration, mode, capture and latch state and the control registers.
module gamepad_to_key_event_mapper (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // operation, pad_present, pad_buttons, stick_x, stick_y, trig_left, trig_right,
    // context_game, action_index, button_id, key_code, one zero pad bit
    input  logic [gkem_pkg::InW-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // key_valid, key_out, key_pressed, capture_id, aim_x, aim_y,
    // trigger_left_level, trigger_right_level
    output logic [gkem_pkg::OutW-1:0]  m_axis_tdata,
    output logic                       m_axis_tlast,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_index,
    input  logic [5:0]                 i_cfg_data
);
    import gkem_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_item item;

    // Unpack the input item.
    assign item.operation    = s_axis_tdata[2:0];
    assign item.pad_present  = s_axis_tdata[3];
    assign item.pad_buttons  = s_axis_tdata[19:4];
    assign item.stick_x      = s_axis_tdata[27:20];
    assign item.stick_y      = s_axis_tdata[35:28];
    assign item.trig_left    = s_axis_tdata[43:36];
    assign item.trig_right   = s_axis_tdata[51:44];
    assign item.context_game = s_axis_tdata[52];
    assign item.action_index = s_axis_tdata[57:53];
    assign item.button_id    = s_axis_tdata[61:58];
    assign item.key_code     = s_axis_tdata[70:62];

    assign o_cfg_ready = 1'b1;

    gkem_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gkem_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// File: hdl/gkem_checker.sv
// Port level checks for the gamepad to key event mapper, bound to the top level.
module gkem_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [gkem_pkg::OutW-1:0] m_axis_tdata,
    input logic                      m_axis_tlast
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Each item is worked on alone: no new item right after one is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken back to back");

    // A result without a key event only closes a run.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tlast)
        else $error("empty result not last");

    // A result without a key event carries a zero key and no press.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[10:1] == 10'd0)
        else $error("empty result carries key data");

endmodule

bind gamepad_to_key_event_mapper gkem_checker u_gkem_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
